/* hdl/cau_pkg.sv */
// shared types, codes and helpers for the complex arithmetic unit
package cau_pkg;

  localparam int CAU_FRAC_BITS = 16;
  // divider remainder width, covers (|sum| << frac) and den << 33
  localparam int CAU_REM_W     = 97;
  // iterative steps: one overflow check plus quotient bits 32 down to 0
  localparam int CAU_STEPS     = 34;
  localparam int CAU_TOP_K     = CAU_STEPS - 1;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4
  } cau_op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  typedef struct packed {
    logic [2:0]           op;
    logic [31:0]          fix_re;
    logic [31:0]          fix_im;
    logic                 fix_sat;
    logic                 divz;
    logic                 neg_re;
    logic                 neg_im;
    logic [CAU_REM_W-1:0] rem_re;
    logic [CAU_REM_W-1:0] rem_im;
    logic [32:0]          q_re;
    logic [32:0]          q_im;
    logic                 ovf_re;
    logic                 ovf_im;
    logic [63:0]          den;
    logic [63:0]          srem;
    logic [31:0]          root;
  } cau_iter_t;

  // clamp a signed value to 32 bits, msb of result is the saturation flag
  function automatic logic [32:0] sat65(input logic signed [64:0] v);
    logic [32:0] r;
    if (v > 65'sd2147483647) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < -65'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // clamp a sign and magnitude quotient
  function automatic logic [32:0] sat_mag(input logic neg, input logic ovf,
                                          input logic [32:0] q);
    logic [32:0] r;
    logic [32:0] nq;
    nq = 33'd0 - q;
    if (!neg) begin
      if (ovf || q > 33'h0_7fff_ffff) r = {1'b1, 32'h7fff_ffff};
      else                            r = {1'b0, q[31:0]};
    end else begin
      if (ovf || q > 33'h0_8000_0000) r = {1'b1, 32'h8000_0000};
      else                            r = {1'b0, nq[31:0]};
    end
    return r;
  endfunction

endpackage

/* hdl/complex_arithmetic_unit.sv */
// complex arithmetic unit top level: front stages, iterative chain, result register
// throughput: one request per cycle, busy is always low
// the depth is set by the 34 divider steps (square root shares those stages)
// reset clears all valid bits, requests in flight are dropped
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_op,
  input  logic signed [31:0] in_a_re,
  input  logic signed [31:0] in_a_im,
  input  logic signed [31:0] in_b_re,
  input  logic signed [31:0] in_b_im,
  output logic               out_valid,
  output logic signed [31:0] out_res_re,
  output logic signed [31:0] out_res_im,
  output logic [1:0]         out_status
);
  import cau_pkg::*;

  logic      v_chain [CAU_STEPS+1];
  cau_iter_t d_chain [CAU_STEPS+1];

  logic        out_valid_r;
  logic [31:0] res_re_r, res_im_r, res_re_nxt, res_im_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [32:0] qr, qi;
  cau_iter_t   fin;

  assign busy = 1'b0;

  cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_op     (in_op),
    .in_a_re   (in_a_re),
    .in_a_im   (in_a_im),
    .in_b_re   (in_b_re),
    .in_b_im   (in_b_im),
    .out_valid (v_chain[0]),
    .out_data  (d_chain[0])
  );

  generate
    for (genvar g = 0; g < CAU_STEPS; g++) begin : g_step
      cau_iter_stage #(.K(CAU_TOP_K - g)) u_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_chain[g]),
        .in_data   (d_chain[g]),
        .out_valid (v_chain[g+1]),
        .out_data  (d_chain[g+1])
      );
    end
  endgenerate

  assign fin = d_chain[CAU_STEPS];
  assign qr  = sat_mag(fin.neg_re, fin.ovf_re, fin.q_re);
  assign qi  = sat_mag(fin.neg_im, fin.ovf_im, fin.q_im);

  always_comb begin
    res_re_nxt = 32'd0;
    res_im_nxt = 32'd0;
    status_nxt = ST_OK;
    case (fin.op) inside
      OP_ADD, OP_SUB, OP_MUL: begin
        res_re_nxt = fin.fix_re;
        res_im_nxt = fin.fix_im;
        status_nxt = fin.fix_sat ? ST_SAT : ST_OK;
      end
      OP_DIV: begin
        if (fin.divz) begin
          status_nxt = ST_DIVZ;
        end else begin
          res_re_nxt = qr[31:0];
          res_im_nxt = qi[31:0];
          status_nxt = (qr[32] | qi[32]) ? ST_SAT : ST_OK;
        end
      end
      OP_MOD: begin
        if (fin.root[31]) begin
          res_re_nxt = 32'h7fff_ffff;
          status_nxt = ST_SAT;
        end else begin
          res_re_nxt = fin.root;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v_chain[CAU_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    res_re_r <= res_re_nxt;
    res_im_r <= res_im_nxt;
    status_r <= status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_res_re = res_re_r;
  assign out_res_im = res_im_r;
  assign out_status = status_r;

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_SAT || out_status == ST_DIVZ))
    else $error("bad status code");

  a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_DIVZ) |-> (out_res_re == 32'd0 && out_res_im == 32'd0))
    else $error("divide by zero result not cleared");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_SAT) |->
      (out_res_re == 32'h7fff_ffff || out_res_re == 32'h8000_0000 ||
       out_res_im == 32'h7fff_ffff || out_res_im == 32'h8000_0000))
    else $error("saturation flagged without a clamped part");

endmodule

/* hdl/cau_front.sv */
// front stages: products, wide sums, operand preparation
module cau_front #(
  parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [2:0]              in_op,
  input  logic signed [31:0]      in_a_re,
  input  logic signed [31:0]      in_a_im,
  input  logic signed [31:0]      in_b_re,
  input  logic signed [31:0]      in_b_im,
  output logic                    out_valid,
  output cau_pkg::cau_iter_t      out_data
);
  import cau_pkg::*;

  // stage 1
  logic               v1_r;
  logic [2:0]         op1_r;
  logic signed [63:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic signed [32:0] as_re_r, as_im_r;
  logic signed [31:0] sq_x, sq_y;

  // stage 2
  logic               v2_r;
  logic [2:0]         op2_r;
  logic signed [64:0] mre_r, mim_r, dre_r, dim_r;
  logic [63:0]        den_r;
  logic signed [32:0] as_re2_r, as_im2_r;

  // stage 3
  logic               v3_r;
  cau_iter_t          d3_r;
  cau_iter_t          d3_nxt;
  logic signed [64:0] mre_sh, mim_sh;
  logic [32:0]        s_re, s_im;
  logic [63:0]        mag_re, mag_im;

  assign sq_x = (in_op == OP_MOD) ? in_a_re : in_b_re;
  assign sq_y = (in_op == OP_MOD) ? in_a_im : in_b_im;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    op1_r   <= in_op;
    p0_r    <= in_a_re * in_b_re;
    p1_r    <= in_a_im * in_b_im;
    p2_r    <= in_a_re * in_b_im;
    p3_r    <= in_a_im * in_b_re;
    p4_r    <= sq_x * sq_x;
    p5_r    <= sq_y * sq_y;
    as_re_r <= (in_op == OP_SUB) ? 33'(in_a_re) - 33'(in_b_re) : 33'(in_a_re) + 33'(in_b_re);
    as_im_r <= (in_op == OP_SUB) ? 33'(in_a_im) - 33'(in_b_im) : 33'(in_a_im) + 33'(in_b_im);
  end

  always_ff @(posedge clk) begin
    op2_r    <= op1_r;
    mre_r    <= 65'(p0_r) - 65'(p1_r);
    mim_r    <= 65'(p2_r) + 65'(p3_r);
    dre_r    <= 65'(p0_r) + 65'(p1_r);
    dim_r    <= 65'(p3_r) - 65'(p2_r);
    den_r    <= $unsigned(p4_r) + $unsigned(p5_r);
    as_re2_r <= as_re_r;
    as_im2_r <= as_im_r;
  end

  assign mre_sh = mre_r >>> FRAC_BITS;
  assign mim_sh = mim_r >>> FRAC_BITS;
  assign mag_re = dre_r[64] ? 64'(-dre_r) : 64'(dre_r);
  assign mag_im = dim_r[64] ? 64'(-dim_r) : 64'(dim_r);

  always_comb begin
    s_re = 33'd0;
    s_im = 33'd0;
    case (op2_r) inside
      OP_ADD, OP_SUB: begin
        s_re = sat65(65'(as_re2_r));
        s_im = sat65(65'(as_im2_r));
      end
      OP_MUL: begin
        s_re = sat65(mre_sh);
        s_im = sat65(mim_sh);
      end
      default: begin
        s_re = 33'd0;
        s_im = 33'd0;
      end
    endcase
    d3_nxt.op      = op2_r;
    d3_nxt.fix_re  = s_re[31:0];
    d3_nxt.fix_im  = s_im[31:0];
    d3_nxt.fix_sat = s_re[32] | s_im[32];
    d3_nxt.divz    = (den_r == 64'd0);
    d3_nxt.neg_re  = dre_r[64];
    d3_nxt.neg_im  = dim_r[64];
    d3_nxt.rem_re  = CAU_REM_W'(mag_re) << FRAC_BITS;
    d3_nxt.rem_im  = CAU_REM_W'(mag_im) << FRAC_BITS;
    d3_nxt.q_re    = 33'd0;
    d3_nxt.q_im    = 33'd0;
    d3_nxt.ovf_re  = 1'b0;
    d3_nxt.ovf_im  = 1'b0;
    d3_nxt.den     = den_r;
    d3_nxt.srem    = den_r;
    d3_nxt.root    = 32'd0;
  end

  always_ff @(posedge clk) begin
    d3_r <= d3_nxt;
  end

  assign out_valid = v3_r;
  assign out_data  = d3_r;

endmodule

/* hdl/cau_iter_stage.sv */
// one stage of the divider and square root pipeline
module cau_iter_stage #(
  parameter int K = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  cau_pkg::cau_iter_t in_data,
  output logic               out_valid,
  output cau_pkg::cau_iter_t out_data
);
  import cau_pkg::*;

  logic      valid_r;
  cau_iter_t data_r;
  cau_iter_t data_nxt;

  logic [CAU_REM_W-1:0] dsh;

  assign dsh = CAU_REM_W'(in_data.den) << K;

  generate
    if (K == CAU_TOP_K) begin : g_ovf
      // quotient would need more than 33 bits
      always_comb begin
        data_nxt        = in_data;
        data_nxt.ovf_re = (in_data.rem_re >= dsh);
        data_nxt.ovf_im = (in_data.rem_im >= dsh);
      end
    end else begin : g_bit
      logic [65:0] trial;
      if (K <= 31) begin : g_sq
        assign trial = ({34'd0, in_data.root} << (K + 1)) + (66'd1 << (2 * K));
      end else begin : g_nosq
        assign trial = '1;
      end
      always_comb begin
        data_nxt = in_data;
        if (!in_data.ovf_re && in_data.rem_re >= dsh) begin
          data_nxt.rem_re  = in_data.rem_re - dsh;
          data_nxt.q_re[K] = 1'b1;
        end
        if (!in_data.ovf_im && in_data.rem_im >= dsh) begin
          data_nxt.rem_im  = in_data.rem_im - dsh;
          data_nxt.q_im[K] = 1'b1;
        end
        if (K <= 31 && {2'b00, in_data.srem} >= trial) begin
          data_nxt.srem = in_data.srem - trial[63:0];
          data_nxt.root = in_data.root | (32'd1 << (K % 32));
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

/* verif/testbench.sv */
// testbench for the complex arithmetic unit: random and directed requests, scoreboard check
`timescale 1ns / 100ps

module testbench;
  import cau_pkg::*;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } cplx_req_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [1:0]         status;
  } cplx_res_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [2:0]         in_op;
  logic signed [31:0] in_a_re, in_a_im, in_b_re, in_b_im;
  logic               out_valid;
  logic signed [31:0] out_res_re, out_res_im;
  logic [1:0]         out_status;

  cplx_req_t pend_q[$];
  cplx_res_t result_q[$];
  logic      taken;
  int        gap_cnt;
  bit        bursty;
  int        n_sent;
  int        n_err;
  bit        stim_done;

  complex_arithmetic_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_a_re(in_a_re), .in_a_im(in_a_im),
    .in_b_re(in_b_re), .in_b_im(in_b_im),
    .out_valid(out_valid), .out_res_re(out_res_re), .out_res_im(out_res_im),
    .out_status(out_status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // clamp to the 32-bit signed range, sets the flag on overflow
  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                 inout bit sat);
    logic signed [31:0] r;
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      r = 32'sh7fff_ffff;
    end else if (v < -128'sd2147483648) begin
      sat = 1'b1;
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] s, res, b;
    s = v;
    res = 64'd0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 64'd0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // truncated quotient of (num << frac) / den, sign applied afterwards
  function automatic logic signed [127:0] frac_quot(input logic signed [127:0] num,
                                                    input logic signed [127:0] den);
    logic signed [127:0] mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag <<< CAU_FRAC_BITS) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic cplx_res_t cplx_compute(input cplx_req_t r);
    cplx_res_t o;
    bit sat;
    logic signed [127:0] ar, ai, br, bi, d;
    sat = 1'b0;
    ar = r.a_re;
    ai = r.a_im;
    br = r.b_re;
    bi = r.b_im;
    o.re = '0;
    o.im = '0;
    o.status = ST_OK;
    case (r.op)
      OP_ADD: begin
        o.re = clamp32(ar + br, sat);
        o.im = clamp32(ai + bi, sat);
      end
      OP_SUB: begin
        o.re = clamp32(ar - br, sat);
        o.im = clamp32(ai - bi, sat);
      end
      OP_MUL: begin
        o.re = clamp32((ar * br - ai * bi) >>> CAU_FRAC_BITS, sat);
        o.im = clamp32((ar * bi + ai * br) >>> CAU_FRAC_BITS, sat);
      end
      OP_DIV: begin
        d = br * br + bi * bi;
        if (d == 0) begin
          o.status = ST_DIVZ;
        end else begin
          o.re = clamp32(frac_quot(ar * br + ai * bi, d), sat);
          o.im = clamp32(frac_quot(ai * br - ar * bi, d), sat);
        end
      end
      OP_MOD: begin
        d = ar * ar + ai * ai;
        o.re = clamp32($signed({64'd0, floor_sqrt(d[63:0])}), sat);
      end
      default: ;
    endcase
    if (sat) o.status = ST_SAT;
    return o;
  endfunction

  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = 32'h7fff_ffff;
      1: v = 32'h8000_0000;
      2: v = '0;
      3, 4: v = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      5: v = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic add_req(input logic [2:0] op, input logic [31:0] ar, input logic [31:0] ai,
                         input logic [31:0] br, input logic [31:0] bi);
    cplx_req_t r;
    r.op = op;
    r.a_re = ar;
    r.a_im = ai;
    r.b_re = br;
    r.b_im = bi;
    pend_q.push_back(r);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (taken) begin
        void'(pend_q.pop_front());
        if (n_sent % 60 == 0) bursty = $urandom_range(0, 1);
        gap_cnt = bursty ? 0 : $urandom_range(0, 12);
      end
      if (gap_cnt != 0) begin
        start <= 1'b0;
        gap_cnt = gap_cnt - 1;
      end else if (pend_q.size() != 0) begin
        start   <= 1'b1;
        in_op   <= pend_q[0].op;
        in_a_re <= pend_q[0].a_re;
        in_a_im <= pend_q[0].a_im;
        in_b_re <= pend_q[0].b_re;
        in_b_im <= pend_q[0].b_im;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // acceptance and result monitor
  always @(posedge clk) begin
    cplx_req_t r;
    cplx_res_t e;
    taken <= rst_n && start && !busy;
    if (rst_n && start && !busy) begin
      r.op = in_op;
      r.a_re = in_a_re;
      r.a_im = in_a_im;
      r.b_re = in_b_re;
      r.b_im = in_b_im;
      result_q.push_back(cplx_compute(r));
      n_sent = n_sent + 1;
    end
    if (rst_n && out_valid) begin
      if (result_q.size() == 0) begin
        n_err = n_err + 1;
        if (n_err <= 10) $display("unexpected result re=%h im=%h st=%0d",
                                  out_res_re, out_res_im, out_status);
      end else begin
        e = result_q.pop_front();
        if (e.re !== out_res_re || e.im !== out_res_im || e.status !== out_status) begin
          n_err = n_err + 1;
          if (n_err <= 10)
            $display("mismatch: exp re=%h im=%h st=%0d, got re=%h im=%h st=%0d",
                     e.re, e.im, e.status, out_res_re, out_res_im, out_status);
        end
      end
    end
  end

  initial begin
    int k;
    logic [2:0] op;
    rst_n = 1'b0;
    start = 1'b0;
    in_op = '0;
    in_a_re = '0;
    in_a_im = '0;
    in_b_re = '0;
    in_b_im = '0;
    taken = 1'b0;
    gap_cnt = 0;
    bursty = 1'b0;
    n_sent = 0;
    n_err = 0;
    stim_done = 1'b0;

    // directed: extremes, each op, zero divisor, unknown codes, ignored operand
    add_req(OP_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff);
    add_req(OP_ADD, 32'h0001_0000, 32'h0002_0000, 32'hfffe_0000, 32'h0000_8000);
    add_req(OP_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff);
    add_req(OP_SUB, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'h0004_0000);
    add_req(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_req(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    add_req(OP_MUL, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    add_req(OP_MUL, 32'h0002_0000, 32'h0001_0000, 32'h0000_8000, 32'hffff_0000);
    add_req(OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 32'h0000_0000);
    add_req(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
    add_req(OP_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
    add_req(OP_DIV, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'hffff_0000);
    add_req(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_req(OP_DIV, 32'h0000_0001, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    add_req(OP_MOD, 32'h8000_0000, 32'h8000_0000, 32'h1234_5678, 32'hdead_beef);
    add_req(OP_MOD, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000);
    add_req(OP_MOD, 32'h0003_0000, 32'hfffc_0000, 32'h0000_0000, 32'h8000_0000);
    add_req(OP_MOD, 32'h0000_0000, 32'h0000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    add_req(3'd5, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    add_req(3'd6, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    add_req(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

    for (k = 0; k < 900; k++) begin
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, 4));
      if (op == OP_DIV && $urandom_range(0, 15) == 0)
        add_req(op, pick_operand(), pick_operand(), '0, '0);
      else
        add_req(op, pick_operand(), pick_operand(), pick_operand(), pick_operand());
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pend_q.size() != 0 || start) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (result_q.size() != 0) n_err = n_err + 1;
    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
